FILE: design/assert_macros.svh
// Assertion macros shared by the debouncer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk outside reset.
`define BDPL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define BDPL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: design/bdpl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button debouncer package
// Operation codes, register indexes and the command and status structs that
// pass between the top level and the per-button cells.
// ----------------------------------------------------------------------------
package bdpl_pkg;

    localparam int unsigned FIELD_W     = 3;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned PRESCALE_W  = 8;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned S_TDATA_W   = 16;
    localparam int unsigned M_TDATA_W   = 8;

    localparam logic [COUNT_W-1:0]    DEBOUNCE_RESET = 4'd10;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd9;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE_RELOAD = 2'd1;

    typedef enum logic [FIELD_W-1:0] {
        OP_TICK            = 3'd0,
        OP_READ_CLEAR      = 3'd1,
        OP_PUSHED_RELEASED = 3'd2,
        OP_LEVEL           = 3'd3,
        OP_CLEAR_ALL       = 3'd4
    } opcode_t;

    typedef struct packed {
        logic               tick;
        logic               raw;
        logic               presc_zero;
        logic               clear;
        logic [COUNT_W-1:0] debounce_time;
    } btn_cmd_t;

    typedef struct packed {
        logic level_now;
        logic flag_now;
        logic level_next;
        logic flag_next;
    } btn_stat_t;

endpackage
`default_nettype wire

FILE: design/button_debounce_press_latch_unit.sv
`default_nettype none
// An accepted word enters the input register and then the result register driving m_axis.
// Throughput: one word per cycle, sustained; while a result waits to be taken the
// input register holds one more word, after which the input stalls.
// All work for a word is one pass through the button cells between the two registers.
// Reset (aresetn, synchronous, active low) clears levels, flags and the prescaler,
// loads every lockout count with 10 and restores the register defaults.
// ----------------------------------------------------------------------------
// Three-button debouncer with press latch
// Debounces raw button levels on tick words and answers press, release and
// level queries, one result word for every input word.
// ----------------------------------------------------------------------------
module button_debounce_press_latch_unit
    import bdpl_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [2:0] opcode, [5:3] button_number, [8:6] raw_levels, rest zero
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] answer, [3:1] levels after the word, [6:4] flags after the word, [7] zero
    output logic [M_TDATA_W-1:0]       m_axis_tdata
);

`include "assert_macros.svh"

    logic [COUNT_W-1:0]    debounce_time_reg;
    logic [PRESCALE_W-1:0] prescale_reload_reg;

    logic                  in_valid_reg;
    logic [FIELD_W-1:0]    in_op_reg;
    logic [FIELD_W-1:0]    in_num_reg;
    logic [FIELD_W-1:0]    in_raw_reg;

    logic                  out_valid_reg;
    logic                  out_answer_reg, out_answer_next;
    logic [FIELD_W-1:0]    out_levels_reg, out_levels_next;
    logic [FIELD_W-1:0]    out_flags_reg, out_flags_next;

    logic                  advance;
    logic                  accept;
    logic                  presc_zero;
    logic                  is_tick;
    opcode_t               op;

    btn_cmd_t              cmd  [NUM_BUTTONS];
    btn_stat_t             stat [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] hit_vec;

    // Handshake: the input register moves on whenever the result register is
    // empty or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = opcode_t'(in_op_reg);
    assign is_tick       = advance && (op == OP_TICK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg   <= DEBOUNCE_RESET;
            prescale_reload_reg <= PRESCALE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DEBOUNCE_TIME:   debounce_time_reg   <= cfg_wdata[COUNT_W-1:0];
                REG_PRESCALE_RELOAD: prescale_reload_reg <= cfg_wdata[PRESCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_op_reg  <= s_axis_tdata[2:0];
            in_num_reg <= s_axis_tdata[5:3];
            in_raw_reg <= s_axis_tdata[8:6];
        end
    end

    bdpl_prescaler u_prescaler (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick       (is_tick),
        .reload     (prescale_reload_reg),
        .zero_after (presc_zero)
    );

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
        logic sel;
        logic raw_bit;

        // Button i answers to number i+1; a number of 0 or past the count
        // selects nothing.
        assign sel = ({1'b0, in_num_reg} == 4'(i + 1));
        if (i < FIELD_W) begin : g_raw
            assign raw_bit = in_raw_reg[i];
        end else begin : g_noraw
            assign raw_bit = 1'b0;
        end

        always_comb begin
            cmd[i].tick          = is_tick;
            cmd[i].raw           = raw_bit;
            cmd[i].presc_zero    = presc_zero;
            cmd[i].debounce_time = debounce_time_reg;
            hit_vec[i]           = 1'b0;
            case (op)
                OP_READ_CLEAR:      hit_vec[i] = sel && stat[i].flag_now;
                OP_PUSHED_RELEASED: hit_vec[i] = sel && stat[i].flag_now
                                                 && !stat[i].level_now;
                OP_LEVEL:           hit_vec[i] = sel && stat[i].level_now;
                default:            hit_vec[i] = 1'b0;
            endcase
            case (op)
                OP_READ_CLEAR:      cmd[i].clear = advance && sel;
                OP_PUSHED_RELEASED: cmd[i].clear = advance && hit_vec[i];
                OP_CLEAR_ALL:       cmd[i].clear = advance;
                default:            cmd[i].clear = 1'b0;
            endcase
        end

        bdpl_button u_button (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd[i]),
            .stat    (stat[i])
        );
    end

    always_comb begin
        out_answer_next = |hit_vec;
        out_levels_next = '0;
        out_flags_next  = '0;
        for (int j = 0; j < FIELD_W; j++) begin
            if (j < NUM_BUTTONS) begin
                out_levels_next[j] = stat[j].level_next;
                out_flags_next[j]  = stat[j].flag_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_axis_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_answer_reg <= out_answer_next;
            out_levels_reg <= out_levels_next;
            out_flags_reg  <= out_flags_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_flags_reg, out_levels_reg, out_answer_reg};

    `BDPL_ASSERT(a_advance_fills, advance |=> m_axis_tvalid, "result word lost after advance")
    `BDPL_ASSERT(a_tick_no_answer, advance && (op == OP_TICK || op == OP_CLEAR_ALL) |=> !out_answer_reg, "tick or clear word gave an answer")
    `BDPL_ASSERT(a_clear_all, advance && op == OP_CLEAR_ALL |=> out_flags_reg == '0, "clear-all left a flag set")
    `BDPL_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_axis_tvalid && !in_valid_reg, "pipeline not empty after reset")

endmodule
`default_nettype wire

FILE: design/bdpl_prescaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared tick prescaler
// Counts down on every tick word and reloads from the prescale register when
// it has reached zero; reports whether the updated value is zero.
// ----------------------------------------------------------------------------
module bdpl_prescaler
    import bdpl_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  tick,
    input  wire logic [PRESCALE_W-1:0] reload,
    output logic                       zero_after
);

    logic [PRESCALE_W-1:0] count_reg;
    logic [PRESCALE_W-1:0] count_next;
    logic [PRESCALE_W-1:0] count_upd;

    always_comb begin
        count_upd  = (count_reg != '0) ? count_reg - 1'b1 : reload;
        count_next = tick ? count_upd : count_reg;
        zero_after = (count_upd == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/bdpl_button.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Per-button debounce cell
// Holds one button's stored level, press flag and lockout count, and applies
// a tick or a flag clear from the shared command.
// ----------------------------------------------------------------------------
module bdpl_button
    import bdpl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire btn_cmd_t cmd,
    output btn_stat_t     stat
);

`include "assert_macros.svh"

    logic               level_reg, level_next;
    logic               flag_reg, flag_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    always_comb begin
        level_next = level_reg;
        flag_next  = flag_reg;
        count_next = count_reg;
        if (cmd.tick) begin
            if (cmd.raw != level_reg) begin
                level_next = cmd.raw;
                // Only an edge outside the lockout window counts.
                if (count_reg == '0) begin
                    if (!cmd.raw) begin
                        count_next = cmd.debounce_time;
                    end else begin
                        flag_next = 1'b1;
                    end
                end
            end else if (cmd.presc_zero && count_reg != '0) begin
                count_next = count_reg - 1'b1;
            end
        end else if (cmd.clear) begin
            flag_next = 1'b0;
        end
    end

    always_comb begin
        stat.level_now  = level_reg;
        stat.flag_now   = flag_reg;
        stat.level_next = level_next;
        stat.flag_next  = flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 1'b0;
            flag_reg  <= 1'b0;
            count_reg <= DEBOUNCE_RESET;
        end else begin
            level_reg <= level_next;
            flag_reg  <= flag_next;
            count_reg <= count_next;
        end
    end

    `BDPL_ASSERT(a_flag_set_by_tick, $rose(flag_reg) |-> $past(cmd.tick) && level_reg, "press flag set without a rising tick")
    `BDPL_ASSERT(a_level_only_on_tick, !cmd.tick |=> level_reg == $past(level_reg), "level changed outside a tick")

endmodule
`default_nettype wire

FILE: test/button_debounce_press_latch_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Debouncer result checker
// Watches the configuration port and both stream channels, keeps its own copy
// of the debouncer state, predicts one result word per accepted input word
// and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module button_debounce_press_latch_checker
    import bdpl_pkg::*;
#(
    parameter int unsigned NUM_BUTTONS = 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [M_TDATA_W-1:0]  m_axis_tdata,
    output int                         failures,
    output int                         pending,
    output int                         results_seen,
    output int                         answers_set
);

    // Same layout as bits [6:0] of the result word; the last member is the lowest.
    typedef struct packed {
        logic [2:0] flags;
        logic [2:0] levels;
        logic       answer;
    } button_result_t;

    logic [COUNT_W-1:0]    debounce_time_q;
    logic [PRESCALE_W-1:0] prescale_reload_q;
    logic [2:0]            level_q;
    logic [2:0]            flag_q;
    logic [COUNT_W-1:0]    lockout_q [3];
    logic [PRESCALE_W-1:0] prescaler_q;

    button_result_t expected_results [$];
    button_result_t want;
    button_result_t got;
    int             mismatches;

    task automatic advance_debouncer(input logic [2:0] op, input logic [2:0] num,
                                     input logic [2:0] raw, output button_result_t res);
        logic known;
        int   b;
        int   i;
        known = (num >= 1) && (num <= NUM_BUTTONS);
        b     = known ? int'(num) - 1 : 0;
        res   = '0;
        case (op)
            OP_TICK: begin
                if (prescaler_q != 0) begin
                    prescaler_q = prescaler_q - 1'b1;
                end else begin
                    prescaler_q = prescale_reload_q;
                end
                for (i = 0; i < 3; i++) begin
                    if (raw[i] != level_q[i]) begin
                        level_q[i] = raw[i];
                        // A change only counts while the lockout has run out.
                        if (lockout_q[i] == 0) begin
                            if (!raw[i]) begin
                                lockout_q[i] = debounce_time_q;
                            end else begin
                                flag_q[i] = 1'b1;
                            end
                        end
                    end else if (prescaler_q == 0 && lockout_q[i] != 0) begin
                        lockout_q[i] = lockout_q[i] - 1'b1;
                    end
                end
            end
            OP_READ_CLEAR: begin
                if (known) begin
                    res.answer = flag_q[b];
                    flag_q[b]  = 1'b0;
                end
            end
            OP_PUSHED_RELEASED: begin
                if (known && flag_q[b] && !level_q[b]) begin
                    res.answer = 1'b1;
                    flag_q[b]  = 1'b0;
                end
            end
            OP_LEVEL: begin
                if (known) begin
                    res.answer = level_q[b];
                end
            end
            OP_CLEAR_ALL: begin
                flag_q = '0;
            end
            default: begin
            end
        endcase
        res.levels = level_q;
        res.flags  = flag_q;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_q   = DEBOUNCE_RESET;
            prescale_reload_q = PRESCALE_RESET;
            level_q           = '0;
            flag_q            = '0;
            prescaler_q       = '0;
            for (int i = 0; i < 3; i++) begin
                lockout_q[i] = DEBOUNCE_RESET;
            end
            expected_results.delete();
            failures     = 0;
            results_seen = 0;
            answers_set  = 0;
            mismatches   = 0;
            pending     <= 0;
        end else begin
            // A result word can never belong to a word accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[6:0];
                results_seen++;
                if (got.answer) begin
                    answers_set++;
                end
                if (expected_results.size() == 0) begin
                    failures++;
                    if (mismatches < 10) begin
                        $display("[%0t] result word 0x%02h arrived with nothing expected",
                                 $time, m_axis_tdata);
                    end
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want || m_axis_tdata[7] != 1'b0) begin
                        failures++;
                        if (mismatches < 10) begin
                            $display("[%0t] mismatch: expected answer=%0b levels=%03b flags=%03b",
                                     $time, want.answer, want.levels, want.flags);
                            $display("[%0t]           got      answer=%0b levels=%03b flags=%03b pad=%0b",
                                     $time, got.answer, got.levels, got.flags, m_axis_tdata[7]);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEBOUNCE_TIME:   debounce_time_q   = cfg_wdata[COUNT_W-1:0];
                    REG_PRESCALE_RELOAD: prescale_reload_q = cfg_wdata[PRESCALE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_debouncer(s_axis_tdata[2:0], s_axis_tdata[5:3], s_axis_tdata[8:6], want);
                expected_results.push_back(want);
            end
            pending <= expected_results.size();
        end
    end

endmodule
`default_nettype wire

FILE: test/button_debounce_press_latch_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Debouncer testbench
// Drives tick, query, clear-all and spare-opcode words into the debouncer
// under several register settings, with random idling on both channels and one
// long output stall, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module button_debounce_press_latch_unit_test
    import bdpl_pkg::*;
();

    localparam int unsigned NUM_BUTTONS    = 3;
    localparam int          PHASES         = 8;
    localparam int          WORDS_PER_PHASE = 215;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          CYCLE_LIMIT    = 600000;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI   = 2'd3;
    localparam logic [FIELD_W-1:0]    OP_SPARE_FIRST = 3'd5;
    localparam logic [FIELD_W-1:0]    OP_SPARE_MID   = 3'd6;
    localparam logic [FIELD_W-1:0]    OP_SPARE_LAST  = 3'd7;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    int failures;
    int pending;
    int results_seen;
    int answers_set;

    int cycles        = 0;
    int words_sent    = 0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int rx_left       = 0;
    int rx_gap;
    logic [2:0] tx_raw = '0;

    logic [COUNT_W-1:0]    phase_debounce [PHASES] =
        '{4'd10, 4'd0, 4'd15, 4'd3, 4'd1, 4'd15, 4'd0, 4'd7};
    logic [PRESCALE_W-1:0] phase_prescale [PHASES] =
        '{8'd9, 8'd0, 8'd255, 8'd1, 8'd2, 8'd0, 8'd255, 8'd4};

    button_debounce_press_latch_unit #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    button_debounce_press_latch_checker #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .failures     (failures),
        .pending      (pending),
        .results_seen (results_seen),
        .answers_set  (answers_set)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: random stalls per word, plus the long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            rx_left       <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served   <= hold_requests;
            rx_left       <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_left != 0) begin
            rx_left       <= rx_left - 1;
            m_axis_tready <= (rx_left == 1);
        end else if (!m_axis_tready || m_axis_tvalid) begin
            rx_gap        = rx_idle_on ? $urandom_range(0, 16) : 0;
            rx_left       <= rx_gap;
            m_axis_tready <= (rx_gap == 0);
        end
    end

    // Leaves tvalid high after the handshake so that back-to-back words
    // never lower and raise it within one time step.
    task automatic send_word(input logic [2:0] op, input logic [2:0] num,
                             input logic [2:0] raw);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, raw, num, op};
        do @(posedge aclk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Leaves cfg_we high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic send_random_word();
        int         pick;
        logic [2:0] op;
        logic [2:0] num;
        logic [2:0] raw;
        pick = $urandom_range(0, 99);
        num  = 3'($urandom_range(0, 7));
        raw  = 3'($urandom_range(0, 7));
        if (pick < 55) begin
            op = OP_TICK;
            // Mostly steady levels with an occasional edge, now and then a burst.
            if (pick < 4) begin
                tx_raw = raw;
            end else if ($urandom_range(0, 5) == 0) begin
                tx_raw = tx_raw ^ 3'(1 << $urandom_range(0, 2));
            end
            raw = tx_raw;
        end else if (pick < 92) begin
            op = 3'($urandom_range(OP_READ_CLEAR, OP_LEVEL));
            if ($urandom_range(0, 7) != 0) begin
                num = 3'($urandom_range(1, NUM_BUTTONS));
            end
        end else if (pick < 96) begin
            op = OP_CLEAR_ALL;
        end else begin
            op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        send_word(op, num, raw);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With no prescaling every tick counts, so the reset lockout of ten
        // runs out after ten quiet ticks and presses start to latch.
        write_reg(REG_PRESCALE_RELOAD, 8'd0);
        write_reg(REG_DEBOUNCE_TIME, 8'hF2);
        write_reg(REG_SPARE_LO, 8'hFF);
        write_reg(REG_SPARE_HI, 8'hFF);
        cfg_we <= 1'b0;
        @(posedge aclk);

        send_word(OP_LEVEL, 3'd0, 3'd7);
        send_word(OP_READ_CLEAR, 3'd7, 3'd0);
        send_word(OP_PUSHED_RELEASED, 3'd4, 3'd7);
        send_word(OP_CLEAR_ALL, 3'd7, 3'd7);
        send_word(OP_SPARE_FIRST, 3'd1, 3'd7);
        send_word(OP_SPARE_LAST, 3'd7, 3'd7);
        repeat (10) send_word(OP_TICK, 3'd0, 3'd0);
        send_word(OP_TICK, 3'd7, 3'd7);
        send_word(OP_LEVEL, 3'd1, 3'd0);
        send_word(OP_PUSHED_RELEASED, 3'd2, 3'd0);
        send_word(OP_READ_CLEAR, 3'd1, 3'd0);
        send_word(OP_TICK, 3'd0, 3'd0);
        send_word(OP_PUSHED_RELEASED, 3'd3, 3'd0);
        send_word(OP_PUSHED_RELEASED, 3'd2, 3'd0);
        send_word(OP_CLEAR_ALL, 3'd0, 3'd0);
        send_word(OP_SPARE_MID, 3'd3, 3'd5);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            // Upper data bits are junk for the four-bit register.
            write_reg(REG_DEBOUNCE_TIME,
                      8'($urandom_range(0, 15) << COUNT_W) | 8'(phase_debounce[p]));
            write_reg(REG_PRESCALE_RELOAD, phase_prescale[p]);
            cfg_we     <= 1'b0;
            tx_idle_on = (p % 4 != 1) && (p % 4 != 3);
            rx_idle_on = (p % 4 != 1) && (p % 4 != 2);
            if (p == 1) begin
                hold_requests++;
            end
            repeat (WORDS_PER_PHASE) send_random_word();
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Run covered %0d words over %0d register settings plus a directed opening;",
                 words_sent, PHASES);
        $display("%0d result words were checked, %0d of them answering one.",
                 results_seen, answers_set);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d result words were wrong", failures);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
